@@ hw/rtl/digitizer_event_stream_parser_assert.svh @@
// assertion macros used by the checker file desp_checker
// no dependencies; include by bare file name
`ifndef DIGITIZER_EVENT_STREAM_PARSER_ASSERT_SVH
`define DIGITIZER_EVENT_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DESP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DESP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/desp_pkg.sv @@
// shared types and codes of the digitizer event stream parser
// no dependencies
`timescale 1ns / 1ps

package desp_pkg;

    localparam int DataWidth = 16;

    // result kinds
    localparam logic [2:0] KIND_SPILL     = 3'd0;
    localparam logic [2:0] KIND_CH_HEADER = 3'd1;
    localparam logic [2:0] KIND_SAMPLE    = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
    localparam logic [2:0] KIND_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] geo;
        logic [7:0]  channel;
        logic [31:0] timestamp;
        logic [16:0] begin_position;
        logic [15:0] sample;
        logic [31:0] header_word;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [DataWidth-1:0] data_word;
        logic                 last_in_buffer;
    } beat_t;

endpackage

@@ hw/rtl/desp_in_if.sv @@
// input channel: one halfword beat with valid/ready
// depends on nothing
`timescale 1ns / 1ps

interface desp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_word;
    logic        last_in_buffer;

    modport source (output valid, output data_word, output last_in_buffer, input ready);
    modport sink   (input valid, input data_word, input last_in_buffer, output ready);
endinterface

@@ hw/rtl/desp_out_if.sv @@
// result channel: one parsed result beat with valid/ready
// depends on nothing
`timescale 1ns / 1ps

interface desp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [11:0] geo;
    logic [7:0]  channel;
    logic [31:0] timestamp;
    logic [16:0] begin_position;
    logic [15:0] sample;
    logic [31:0] header_word;
    logic        last;

    modport source (output valid, output kind, output geo, output channel, output timestamp,
                    output begin_position, output sample, output header_word, output last,
                    input ready);
    modport sink   (input valid, input kind, input geo, input channel, input timestamp,
                    input begin_position, input sample, input header_word, input last,
                    output ready);
endinterface

@@ hw/rtl/digitizer_event_stream_parser.sv @@
// top level of the digitizer event stream parser
// depends on desp_pkg, desp_in_if, desp_out_if, desp_core, desp_out_reg
`timescale 1ns / 1ps

// Parses a digitizer readout buffer given as 16-bit halfwords, low half of
// each 32-bit word first, one halfword per beat on words. Results (spill
// tags, channel headers, samples, unknown-header and truncation errors) come
// out on results, at most one per input beat. Throughput is one halfword per
// clock: a beat is taken every cycle while the result side keeps up, and a
// beat that makes no result moves on even while a result waits. A result
// passes the input register, then the result register, before it shows on
// results. After an unknown header the rest of the buffer up to the beat
// marked last_in_buffer is dropped. pass_through may only be written while
// the block is idle; when set every halfword becomes a sample result.

module digitizer_event_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    desp_in_if.sink    words,
    desp_out_if.source results
);
    import desp_pkg::*;

    // configuration
    logic pass_through_reg;

    // input register
    logic  in_valid_reg, in_valid_next;
    beat_t in_beat_reg;

    logic    accept;
    logic    advance;
    logic    has_result;
    logic    out_free;
    result_t step_result;
    result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pass_through_reg <= 1'b0;
        else if (cfg_write_en)
            pass_through_reg <= cfg_write_data;
    end

    // a held beat moves on if it makes no result or the result register frees up
    assign advance     = in_valid_reg && (!has_result || out_free);
    assign words.ready = !in_valid_reg || advance;
    assign accept      = words.valid && words.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg.data_word      <= words.data_word;
            in_beat_reg.last_in_buffer <= words.last_in_buffer;
        end
    end

    // parse state and step logic, committed when the beat advances
    desp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .pass_through (pass_through_reg),
        .beat         (in_beat_reg),
        .commit       (advance),
        .result       (step_result),
        .has_result   (has_result)
    );

    // result register feeding the result channel
    desp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .load_data (step_result),
        .take      (results.ready),
        .valid     (results.valid),
        .free      (out_free),
        .data      (out_data)
    );

    assign results.kind           = out_data.kind;
    assign results.geo            = out_data.geo;
    assign results.channel        = out_data.channel;
    assign results.timestamp      = out_data.timestamp;
    assign results.begin_position = out_data.begin_position;
    assign results.sample         = out_data.sample;
    assign results.header_word    = out_data.header_word;
    assign results.last           = out_data.last;

endmodule

@@ hw/rtl/desp_core.sv @@
// parse state registers and the single-pass step logic
// depends on desp_pkg
`timescale 1ns / 1ps

module desp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pass_through,
    input  desp_pkg::beat_t  beat,
    input  logic             commit,
    output desp_pkg::result_t result,
    output logic             has_result
);
    import desp_pkg::*;

    localparam logic [1:0] MODE_EVENT   = 2'd0;
    localparam logic [1:0] MODE_CHHDR   = 2'd1;
    localparam logic [1:0] MODE_SAMPLES = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] low_half_reg, low_half_next;
    logic [31:0] first_word_reg, first_word_next;
    logic [4:0]  board_slot_reg, board_slot_next;
    logic        spill_reg, spill_next;
    logic [31:0] event_time_reg, event_time_next;
    logic [24:0] remaining_reg, remaining_next;
    logic [11:0] ch_slot_reg, ch_slot_next;
    logic [7:0]  ch_index_reg, ch_index_next;
    logic [13:0] samples_reg, samples_next;
    logic [15:0] start_pos_reg, start_pos_next;

    logic [15:0] w;
    logic [31:0] word32;
    logic [24:0] remaining_dec;
    logic [13:0] samples_dec;
    logic        clean;

    always_comb
    begin
        w             = beat.data_word;
        word32        = {w, low_half_reg};
        remaining_dec = (remaining_reg != '0) ? remaining_reg - 25'd1 : remaining_reg;
        samples_dec   = (samples_reg != '0) ? samples_reg - 14'd1 : samples_reg;

        mode_next       = mode_reg;
        phase_next      = phase_reg;
        low_half_next   = low_half_reg;
        first_word_next = first_word_reg;
        board_slot_next = board_slot_reg;
        spill_next      = spill_reg;
        event_time_next = event_time_reg;
        remaining_next  = remaining_reg;
        ch_slot_next    = ch_slot_reg;
        ch_index_next   = ch_index_reg;
        samples_next    = samples_reg;
        start_pos_next  = start_pos_reg;
        result          = '0;
        has_result      = 1'b0;
        clean           = 1'b0;

        if (pass_through)
        begin
            result.kind   = KIND_SAMPLE;
            result.geo    = 12'd2;
            result.sample = w;
            result.last   = beat.last_in_buffer;
            has_result    = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_EVENT:
                begin
                    unique case (phase_reg)
                        3'd1:
                        begin
                            if (w[15:12] != 4'ha)
                            begin
                                result.kind        = KIND_UNKNOWN;
                                result.header_word = word32;
                                has_result         = 1'b1;
                                mode_next          = MODE_DISCARD;
                            end
                            else
                            begin
                                first_word_next = word32;
                                remaining_next  = (word32[23:0] > 24'd6) ?
                                                  {1'b0, word32[23:0] - 24'd6} : '0;
                                phase_next      = 3'd2;
                            end
                        end
                        3'd3:
                        begin
                            board_slot_next = w[15:11];
                            spill_next      = ({w[7:0], low_half_reg[15:8]} == 16'hfff7);
                            phase_next      = 3'd4;
                        end
                        3'd5:
                        begin
                            event_time_next = word32;
                            if (spill_reg)
                            begin
                                result.kind        = KIND_SPILL;
                                result.geo         = {7'd0, board_slot_reg};
                                result.channel     = 8'hff;
                                result.timestamp   = word32;
                                result.header_word = first_word_reg;
                                result.last        = 1'b1;
                                has_result         = 1'b1;
                            end
                            mode_next  = (remaining_reg != '0) ? MODE_CHHDR : MODE_EVENT;
                            phase_next = 3'd0;
                        end
                        default:
                        begin
                            low_half_next = w;
                            phase_next    = phase_reg + 3'd1;
                        end
                    endcase
                end
                MODE_CHHDR:
                begin
                    remaining_next = remaining_dec;
                    unique case (phase_reg)
                        3'd1:
                        begin
                            if (w[15:12] != 4'h3)
                            begin
                                result.kind        = KIND_UNKNOWN;
                                result.header_word = word32;
                                has_result         = 1'b1;
                                mode_next          = MODE_DISCARD;
                            end
                            else
                            begin
                                ch_slot_next  = w[11:0];
                                ch_index_next = low_half_reg[7:0];
                                phase_next    = 3'd2;
                            end
                        end
                        3'd3:
                        begin
                            start_pos_next        = low_half_reg;
                            samples_next          = w[13:0];
                            result.kind           = KIND_CH_HEADER;
                            result.geo            = ch_slot_reg;
                            result.channel        = ch_index_reg;
                            result.timestamp      = event_time_reg;
                            result.begin_position = {low_half_reg, 1'b0};
                            result.last           = (w[13:0] == '0);
                            has_result            = 1'b1;
                            if (w[13:0] != '0)
                            begin
                                mode_next  = MODE_SAMPLES;
                                phase_next = 3'd0;
                            end
                            else
                            begin
                                mode_next  = (remaining_dec != '0) ? MODE_CHHDR : MODE_EVENT;
                                phase_next = 3'd0;
                            end
                        end
                        default:
                        begin
                            low_half_next = w;
                            phase_next    = phase_reg + 3'd1;
                        end
                    endcase
                end
                MODE_SAMPLES:
                begin
                    remaining_next        = remaining_dec;
                    samples_next          = samples_dec;
                    result.kind           = KIND_SAMPLE;
                    result.geo            = ch_slot_reg;
                    result.channel        = ch_index_reg;
                    result.timestamp      = event_time_reg;
                    result.begin_position = {start_pos_reg, 1'b0};
                    result.sample         = w;
                    result.last           = (samples_dec == '0);
                    has_result            = 1'b1;
                    if (samples_dec == '0)
                    begin
                        mode_next  = (remaining_dec != '0) ? MODE_CHHDR : MODE_EVENT;
                        phase_next = 3'd0;
                    end
                end
                MODE_DISCARD:
                begin
                end
            endcase

            // end of buffer: flag an unfinished event or record, then resync
            if (beat.last_in_buffer)
            begin
                clean = (mode_next == MODE_EVENT && phase_next == 3'd0) ||
                        (mode_next == MODE_DISCARD);
                if (!clean && !(has_result && result.kind == KIND_UNKNOWN))
                begin
                    result      = '0;
                    result.kind = KIND_TRUNCATED;
                    has_result  = 1'b1;
                end
                mode_next  = MODE_EVENT;
                phase_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_EVENT;
            phase_reg      <= '0;
            low_half_reg   <= '0;
            first_word_reg <= '0;
            board_slot_reg <= '0;
            spill_reg      <= 1'b0;
            event_time_reg <= '0;
            remaining_reg  <= '0;
            ch_slot_reg    <= '0;
            ch_index_reg   <= '0;
            samples_reg    <= '0;
            start_pos_reg  <= '0;
        end
        else if (commit)
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            low_half_reg   <= low_half_next;
            first_word_reg <= first_word_next;
            board_slot_reg <= board_slot_next;
            spill_reg      <= spill_next;
            event_time_reg <= event_time_next;
            remaining_reg  <= remaining_next;
            ch_slot_reg    <= ch_slot_next;
            ch_index_reg   <= ch_index_next;
            samples_reg    <= samples_next;
            start_pos_reg  <= start_pos_next;
        end
    end

endmodule

@@ hw/rtl/desp_out_reg.sv @@
// result register between the step logic and the result channel
// depends on desp_pkg
`timescale 1ns / 1ps

module desp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  desp_pkg::result_t load_data,
    input  logic              take,
    output logic              valid,
    output logic              free,
    output desp_pkg::result_t data
);
    import desp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign free  = !valid_reg || take;
    assign data  = data_reg;

endmodule

@@ hw/rtl/desp_checker.sv @@
// port-level checks of the result channel, bound to the top level
// depends on desp_pkg and digitizer_event_stream_parser_assert.svh
`timescale 1ns / 1ps
`include "digitizer_event_stream_parser_assert.svh"

module desp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  kind,
    input logic [11:0] geo,
    input logic [7:0]  channel,
    input logic [31:0] timestamp,
    input logic [16:0] begin_position,
    input logic [15:0] sample,
    input logic [31:0] header_word,
    input logic        last
);
    import desp_pkg::*;

    // a stalled result beat holds its kind, sample, header word and last flag
    `DESP_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(kind) && $stable(sample) && $stable(header_word) && $stable(last), "result beat changed under stall")

    // spill tag carries no channel and always closes its record
    `DESP_ASSERT_NOW(a_spill_shape, clk, rst_n, res_valid && kind == KIND_SPILL, channel == 8'hff && last && begin_position == '0 && sample == '0, "malformed spill result")

    // truncation carries nothing else
    `DESP_ASSERT_NOW(a_trunc_zero, clk, rst_n, res_valid && kind == KIND_TRUNCATED, geo == '0 && channel == '0 && timestamp == '0 && header_word == '0 && !last, "truncation result not clean")

    // unknown header carries only the offending word
    `DESP_ASSERT_NOW(a_unknown_zero, clk, rst_n, res_valid && kind == KIND_UNKNOWN, geo == '0 && timestamp == '0 && sample == '0 && !last, "unknown header result not clean")

endmodule

bind digitizer_event_stream_parser desp_checker u_desp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .kind           (results.kind),
    .geo            (results.geo),
    .channel        (results.channel),
    .timestamp      (results.timestamp),
    .begin_position (results.begin_position),
    .sample         (results.sample),
    .header_word    (results.header_word),
    .last           (results.last)
);
